// ----- hw/rtl/rthv_pkg.sv -----
// ----------------------------------------------------------------------------
// rthv_pkg: shared types and constants of the RGB to hue/value converter
// Stage payload structs, hue sector codes and fixed hue offsets.
// ----------------------------------------------------------------------------
package rthv_pkg;

   localparam int CHAN_W         = 8;
   localparam int HUE_W          = 13;
   localparam int QUO_W          = 10;
   localparam int NUM_W          = CHAN_W + QUO_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

   localparam logic [HUE_W-1:0] HUE_FULL       = 13'd5760;
   localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 13'd1920;
   localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 13'd3840;
   localparam logic [QUO_W-1:0] QUO_MAX        = 10'd960;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE,
      SECTOR_GRAY
   } sector_type;

   typedef struct packed {
      sector_type          sector;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [CHAN_W-1:0]   vmax;
      logic [CHAN_W-1:0]   vmin;
      logic [CHAN_W-1:0]   alpha;
   } sort_type;

   typedef struct packed {
      sector_type          sector;
      logic                neg;
      logic [CHAN_W-1:0]   vmax;
      logic [CHAN_W-1:0]   alpha;
      logic [CHAN_W-1:0]   dlt;
      logic [CHAN_W-1:0]   rem;
      logic [QUO_W-1:0]    numl;
      logic [QUO_W-1:0]    quo;
   } div_type;

endpackage

// ----- hw/rtl/rgb_to_hsv_hue_value_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_hue_value_top: RGB to hue/value pixel converter
// Channel  | Direction | Transaction fields
// req_     | in        | red, green, blue, alpha_in (8 bits each)
// rsp_     | out       | hue (13 bits, 1/16 degree), brightness, alpha_out
//
// Accepts one pixel per cycle while req_ready is high; each pixel passes
// through eight register stages in all.
// The restoring divider has five slices, two quotient bits each.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while the next one is full and stalled; empty stages
// keep filling, so a stalled output does not block new transactions at once.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hue_value_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rthv_pkg::CHAN_W-1:0]   req_red,
   input  logic [rthv_pkg::CHAN_W-1:0]   req_green,
   input  logic [rthv_pkg::CHAN_W-1:0]   req_blue,
   input  logic [rthv_pkg::CHAN_W-1:0]   req_alpha_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rthv_pkg::HUE_W-1:0]    rsp_hue,
   output logic [rthv_pkg::CHAN_W-1:0]   rsp_brightness,
   output logic [rthv_pkg::CHAN_W-1:0]   rsp_alpha_out
);
   import rthv_pkg::*;

   sort_type sort_data;
   logic     sort_valid, sort_ready;
   div_type  div_data  [DIV_STAGES+1];
   logic     div_valid [DIV_STAGES+1];
   logic     div_ready [DIV_STAGES+1];

   rthv_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .in_alpha  (req_alpha_in),
      .out_valid (sort_valid),
      .out_ready (sort_ready),
      .out_data  (sort_data)
   );

   rthv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sort_valid),
      .in_ready  (sort_ready),
      .in_data   (sort_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rthv_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   rthv_hue u_hue (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (div_valid[DIV_STAGES]),
      .in_ready       (div_ready[DIV_STAGES]),
      .in_data        (div_data[DIV_STAGES]),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_hue        (rsp_hue),
      .out_brightness (rsp_brightness),
      .out_alpha      (rsp_alpha_out)
   );

endmodule

// ----- hw/rtl/rthv_sort.sv -----
// ----------------------------------------------------------------------------
// rthv_sort: channel ordering stage
// Finds the largest and smallest channel and the hue sector of a pixel.
// ----------------------------------------------------------------------------
module rthv_sort (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rthv_pkg::CHAN_W-1:0]   in_red,
   input  logic [rthv_pkg::CHAN_W-1:0]   in_green,
   input  logic [rthv_pkg::CHAN_W-1:0]   in_blue,
   input  logic [rthv_pkg::CHAN_W-1:0]   in_alpha,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rthv_pkg::sort_type            out_data
);
   import rthv_pkg::*;

   logic     valid_ff, valid_in;
   sort_type data_ff, data_in;
   logic     r_ge_g, r_ge_b, g_ge_b;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      r_ge_g        = in_red >= in_green;
      r_ge_b        = in_red >= in_blue;
      g_ge_b        = in_green >= in_blue;
      data_in.red   = in_red;
      data_in.green = in_green;
      data_in.blue  = in_blue;
      data_in.alpha = in_alpha;
      if (r_ge_g && r_ge_b) begin
         data_in.sector = SECTOR_RED;
         data_in.vmax   = in_red;
      end else if (g_ge_b) begin
         data_in.sector = SECTOR_GREEN;
         data_in.vmax   = in_green;
      end else begin
         data_in.sector = SECTOR_BLUE;
         data_in.vmax   = in_blue;
      end
      if (!r_ge_g && !r_ge_b) begin
         data_in.vmin = in_red;
      end else if (!g_ge_b) begin
         data_in.vmin = in_green;
      end else begin
         data_in.vmin = in_blue;
      end
      if (in_red == in_green && in_green == in_blue) begin
         data_in.sector = SECTOR_GRAY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hw/rtl/rthv_prep.sv -----
// ----------------------------------------------------------------------------
// rthv_prep: divider setup stage
// Forms the channel spread, the signed sector offset and the scaled dividend.
// ----------------------------------------------------------------------------
module rthv_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rthv_pkg::sort_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rthv_pkg::div_type    out_data
);
   import rthv_pkg::*;

   logic              valid_ff, valid_in;
   div_type           data_ff, data_in;
   logic [CHAN_W-1:0] op_p, op_q, mag;
   logic [NUM_W-1:0]  num;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      case (in_data.sector)
         SECTOR_RED: begin
            op_p = in_data.green;
            op_q = in_data.blue;
         end
         SECTOR_GREEN: begin
            op_p = in_data.blue;
            op_q = in_data.red;
         end
         default: begin
            op_p = in_data.red;
            op_q = in_data.green;
         end
      endcase
      data_in.neg    = op_p < op_q;
      mag            = data_in.neg ? (op_q - op_p) : (op_p - op_q);
      num            = {mag, {QUO_W{1'b0}}} - {{(QUO_W-6){1'b0}}, mag, 6'b0};
      data_in.sector = in_data.sector;
      data_in.vmax   = in_data.vmax;
      data_in.alpha  = in_data.alpha;
      data_in.dlt    = in_data.vmax - in_data.vmin;
      data_in.rem    = num[NUM_W-1:QUO_W];
      data_in.numl   = num[QUO_W-1:0];
      data_in.quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hw/rtl/rthv_div_stage.sv -----
// ----------------------------------------------------------------------------
// rthv_div_stage: restoring divider slice
// Retires two quotient bits of the sector offset divided by the spread.
// ----------------------------------------------------------------------------
module rthv_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rthv_pkg::div_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rthv_pkg::div_type    out_data
);
   import rthv_pkg::*;

   logic            valid_ff, valid_in;
   div_type         data_ff, data_in;
   logic [CHAN_W:0] trial;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in = in_data;
      trial   = '0;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         trial        = {data_in.rem, data_in.numl[QUO_W-1]};
         data_in.numl = {data_in.numl[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, data_in.dlt}) begin
            trial       = trial - {1'b0, data_in.dlt};
            data_in.quo = {data_in.quo[QUO_W-2:0], 1'b1};
         end else begin
            data_in.quo = {data_in.quo[QUO_W-2:0], 1'b0};
         end
         data_in.rem = trial[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hw/rtl/rthv_hue.sv -----
// ----------------------------------------------------------------------------
// rthv_hue: hue assembly and output register
// Adds the quotient to the sector base or subtracts it (zero hue for gray), wraps negative hues, holds the result.
// ----------------------------------------------------------------------------
module rthv_hue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rthv_pkg::div_type             in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [rthv_pkg::HUE_W-1:0]    out_hue,
   output logic [rthv_pkg::CHAN_W-1:0]   out_brightness,
   output logic [rthv_pkg::CHAN_W-1:0]   out_alpha
);
   import rthv_pkg::*;

   logic              valid_ff, valid_in;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [CHAN_W-1:0] bright_ff, alpha_ff;
   logic [HUE_W-1:0]  quo_ext, quo_up;

   assign in_ready       = !valid_ff || out_ready;
   assign out_valid      = valid_ff;
   assign out_hue        = hue_ff;
   assign out_brightness = bright_ff;
   assign out_alpha      = alpha_ff;
   assign valid_in       = in_ready ? in_valid : valid_ff;

   always_comb begin
      quo_ext = {{(HUE_W-QUO_W){1'b0}}, in_data.quo};
      quo_up  = quo_ext + {{(HUE_W-1){1'b0}}, (in_data.rem != '0)};
      case (in_data.sector)
         SECTOR_RED: begin
            if (in_data.neg && in_data.quo != '0) begin
               hue_in = HUE_FULL - quo_ext;
            end else if (in_data.neg) begin
               hue_in = '0;
            end else begin
               hue_in = quo_ext;
            end
         end
         SECTOR_GREEN: begin
            hue_in = in_data.neg ? (HUE_BASE_GREEN - quo_up) : (HUE_BASE_GREEN + quo_ext);
         end
         SECTOR_BLUE: begin
            hue_in = in_data.neg ? (HUE_BASE_BLUE - quo_up) : (HUE_BASE_BLUE + quo_ext);
         end
         default: begin
            hue_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hue_ff    <= hue_in;
         bright_ff <= in_data.vmax;
         alpha_ff  <= in_data.alpha;
      end
   end

`ifndef SYNTHESIS
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> hue_ff < HUE_FULL)
      else $error("hue out of range");

   a_gray_zero: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && in_data.sector == SECTOR_GRAY) |=> hue_ff == '0)
      else $error("achromatic pixel gave nonzero hue");

   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_data.sector != SECTOR_GRAY) |-> in_data.quo <= QUO_MAX)
      else $error("quotient exceeds sixty degrees");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_data.sector != SECTOR_GRAY) |-> in_data.rem < in_data.dlt)
      else $error("divider remainder not below divisor");
`endif

endmodule
